/* src/page_tag_table_core_assert.svh */
// ----------------------------------------------------------------------------
// page_tag_table_core_assert
// assertion macros for the page tag table
// ----------------------------------------------------------------------------
`ifndef PAGE_TAG_TABLE_CORE_ASSERT_SVH
`define PAGE_TAG_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PTT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page tag table check failed");

// next-cycle implication, checked out of reset
`define PTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page tag table check failed");

`endif

/* src/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// types and constants shared by the page tag table modules
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int ADDR_W    = 48;
    localparam int TAG_W     = 8;
    localparam int DIST_W    = 7;
    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 21;
    localparam int LHB_W     = 12;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [TAG_W-1:0] TAG_LARGE = 8'h80;
    localparam logic [LHB_W-1:0] LHB_RESET = 12'd64;

    localparam logic [KIND_W-1:0] KIND_SMALL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LARGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_HDR   = 1'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_LOOKUP_RD,
        S_LOOKUP_CALC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  block_header_address;
        logic [COUNT_W-1:0] page_count;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] header_address;
        logic              is_large;
        logic [DIST_W-1:0] distance;
        logic              out_of_range;
    } out_item_t;

endpackage

/* src/page_tag_table_core.sv */
// ----------------------------------------------------------------------------
// page_tag_table_core
// big-bag-of-pages tag table: registers small and large page ranges and
// resolves a pointer to its block header
// ----------------------------------------------------------------------------
// lookup: S_DECODE, S_LOOKUP_RD, S_LOOKUP_CALC, then S_EMIT, which waits for a
//   free output register; only then the next item; register: page_count writes
//   (clipped at table end), one tag write per cycle through the single memory
//   write port; reset: clears all 2**INDEX_BITS tag entries, one per cycle, no
//   item accepted meanwhile; config registers return to defaults at once
module page_tag_table_core #(
    parameter int INDEX_BITS = 20,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ptt_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ptt_pkg::out_item_t            out_item,
    input  logic                          cfg_wr_en,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_data
);

`include "page_tag_table_core_assert.svh"

    ptt_pkg::state_t state_reg, state_next;

    logic [ptt_pkg::ADDR_W-1:0]   base_reg;
    logic [ptt_pkg::LHB_W-1:0]    lhb_reg;

    ptt_pkg::in_item_t            item_reg, item_next;
    logic [INDEX_BITS:0]          widx_reg, widx_next;
    logic [ptt_pkg::COUNT_W-1:0]  remain_reg, remain_next;
    logic [ptt_pkg::DIST_W-1:0]   dist_reg, dist_next;
    ptt_pkg::out_item_t           res_reg, res_next;
    ptt_pkg::out_item_t           out_item_reg, out_item_next;
    logic                         out_valid_reg, out_valid_next;

    logic                         ram_we;
    logic [INDEX_BITS-1:0]        ram_waddr;
    logic [ptt_pkg::TAG_W-1:0]    ram_wdata;
    logic                         ram_re;
    logic [ptt_pkg::TAG_W-1:0]    ram_rdata;

    logic [ptt_pkg::ADDR_W-1:0]   offset;
    logic [ptt_pkg::ADDR_W-1:0]   hdr_gap;
    ptt_pkg::out_item_t           calc_res;
    logic                         in_fire;
    logic                         out_free;

    ptt_tag_ram #(
        .ADDR_BITS (INDEX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (widx_reg[INDEX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    ptt_header_calc #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_calc (
        .address            (item_reg.address),
        .tag                (ram_rdata),
        .large_header_bytes (lhb_reg),
        .result             (calc_res)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            lhb_reg  <= ptt_pkg::LHB_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ptt_pkg::CFG_REGION_BASE: base_reg <= cfg_data[ptt_pkg::ADDR_W-1:0];
                ptt_pkg::CFG_LARGE_HDR:   lhb_reg  <= cfg_data[ptt_pkg::LHB_W-1:0];
                default:                  base_reg <= base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptt_pkg::S_CLEAR;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        remain_reg   <= remain_next;
        dist_reg     <= dist_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign offset   = item_reg.address - base_reg;
    assign hdr_gap  = item_reg.address - item_reg.block_header_address
                      - {{(ptt_pkg::ADDR_W-1){1'b0}}, 1'b1};
    assign in_ready = (state_reg == ptt_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        widx_next      = widx_reg;
        remain_next    = remain_reg;
        dist_next      = dist_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_waddr      = widx_reg[INDEX_BITS-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;

        case (state_reg)
            ptt_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                widx_next = widx_reg + 1'b1;
                if (&widx_reg[INDEX_BITS-1:0])
                begin
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            ptt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next  = in_item;
                    state_next = ptt_pkg::S_DECODE;
                end
            end
            ptt_pkg::S_DECODE:
            begin
                widx_next   = {1'b0, offset[PAGE_SHIFT +: INDEX_BITS]};
                remain_next = item_reg.page_count;
                dist_next   = hdr_gap[PAGE_SHIFT +: ptt_pkg::DIST_W];
                res_next    = '0;
                case (item_reg.kind)
                    ptt_pkg::KIND_SMALL:  state_next = ptt_pkg::S_WRITE;
                    ptt_pkg::KIND_LARGE:  state_next = ptt_pkg::S_WRITE;
                    ptt_pkg::KIND_LOOKUP: state_next = ptt_pkg::S_LOOKUP_RD;
                    default:              state_next = ptt_pkg::S_EMIT;
                endcase
            end
            ptt_pkg::S_WRITE:
            begin
                if (remain_reg == '0)
                begin
                    state_next = ptt_pkg::S_EMIT;
                end
                else if (widx_reg[INDEX_BITS])
                begin
                    // range ran past the table end
                    res_next.out_of_range = 1'b1;
                    state_next            = ptt_pkg::S_EMIT;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = (item_reg.kind == ptt_pkg::KIND_LARGE) ?
                                  ptt_pkg::TAG_LARGE : {1'b0, dist_reg};
                    widx_next   = widx_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    dist_next   = dist_reg + 1'b1;
                end
            end
            ptt_pkg::S_LOOKUP_RD:
            begin
                ram_re     = 1'b1;
                state_next = ptt_pkg::S_LOOKUP_CALC;
            end
            ptt_pkg::S_LOOKUP_CALC:
            begin
                res_next   = calc_res;
                state_next = ptt_pkg::S_EMIT;
            end
            ptt_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ptt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `PTT_ASSERT_IMPLY(a_no_accept_in_clear, state_reg == ptt_pkg::S_CLEAR, !in_ready)
    `PTT_ASSERT_IMPLY(a_we_states, ram_we,
        state_reg == ptt_pkg::S_CLEAR || state_reg == ptt_pkg::S_WRITE)
    `PTT_ASSERT_IMPLY(a_write_in_table, ram_we, !widx_reg[INDEX_BITS])
    `PTT_ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, state_reg == ptt_pkg::S_DECODE)

endmodule

/* src/ptt_tag_ram.sv */
// ----------------------------------------------------------------------------
// ptt_tag_ram
// tag store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ptt_tag_ram #(
    parameter int ADDR_BITS = 20
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_BITS-1:0]        waddr,
    input  logic [ptt_pkg::TAG_W-1:0]   wdata,
    input  logic                        re,
    input  logic [ADDR_BITS-1:0]        raddr,
    output logic [ptt_pkg::TAG_W-1:0]   rdata
);

    logic [ptt_pkg::TAG_W-1:0] tag_mem [(1 << ADDR_BITS)];
    logic [ptt_pkg::TAG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tag_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= tag_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ptt_header_calc.sv */
// ----------------------------------------------------------------------------
// ptt_header_calc
// decodes a looked-up tag into the block header address
// ----------------------------------------------------------------------------
module ptt_header_calc #(
    parameter int PAGE_SHIFT = 12
) (
    input  logic [ptt_pkg::ADDR_W-1:0] address,
    input  logic [ptt_pkg::TAG_W-1:0]  tag,
    input  logic [ptt_pkg::LHB_W-1:0]  large_header_bytes,
    output ptt_pkg::out_item_t         result
);

    logic                         tag_is_large;
    logic [ptt_pkg::DIST_W-1:0]   tag_dist;
    logic [ptt_pkg::ADDR_W-1:0]   page_num;
    logic [ptt_pkg::ADDR_W-1:0]   page_diff;
    logic [ptt_pkg::ADDR_W-1:0]   small_hdr;
    logic [ptt_pkg::ADDR_W-1:0]   large_hdr;

    assign tag_is_large = tag[ptt_pkg::TAG_W-1];
    assign tag_dist     = tag[ptt_pkg::DIST_W-1:0];
    assign page_num     = address >> PAGE_SHIFT;
    assign page_diff    = page_num - {{(ptt_pkg::ADDR_W-ptt_pkg::DIST_W){1'b0}}, tag_dist}
                          - {{(ptt_pkg::ADDR_W-1){1'b0}}, 1'b1};
    assign small_hdr    = page_diff << PAGE_SHIFT;
    assign large_hdr    = address
                          - {{(ptt_pkg::ADDR_W-ptt_pkg::LHB_W){1'b0}}, large_header_bytes};

    always_comb
    begin
        result.header_address = tag_is_large ? large_hdr : small_hdr;
        result.is_large       = tag_is_large;
        result.distance       = tag_dist;
        result.out_of_range   = 1'b0;
    end

endmodule

/* tb/ptt_result_check.sv */
// ----------------------------------------------------------------------------
// ptt_result_check
// watches the item, result and register ports of the page tag table, keeps
// its own copy of the tag store and settings, and compares every result with
// the oldest prediction
// ----------------------------------------------------------------------------
module ptt_result_check
    import ptt_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    checked
);

    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int REPORT_LIMIT = 10;

    bit [TAG_W-1:0]    tag_mirror [TABLE_DEPTH];
    logic [ADDR_W-1:0] base_addr = '0;
    logic [LHB_W-1:0]  hdr_bytes = LHB_RESET;
    out_item_t         header_q [$];
    int                fail_count = 0;
    int                waiting = 0;
    int                seen = 0;

    assign mismatches = fail_count;
    assign pending    = waiting;
    assign checked    = seen;

    function automatic logic [INDEX_BITS-1:0] page_slot(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] offset;
        offset = addr - base_addr;
        return offset[PAGE_SHIFT +: INDEX_BITS];
    endfunction

    // applies one item to the mirror and returns the result it must produce
    function automatic out_item_t apply_tag_op(in_item_t it);
        out_item_t         res;
        longint unsigned   start;
        longint unsigned   room;
        longint unsigned   n;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] page;
        logic [DIST_W-1:0] next_dist;
        logic [TAG_W-1:0]  tag;
        res = '0;
        case (it.kind)
            KIND_SMALL, KIND_LARGE:
            begin
                start     = page_slot(it.address);
                room      = TABLE_DEPTH - start;
                n         = it.page_count;
                span      = it.address - it.block_header_address - 1;
                next_dist = span[PAGE_SHIFT +: DIST_W];
                if (n > room)
                begin
                    n = room;
                    res.out_of_range = 1'b1;
                end
                for (longint unsigned i = 0; i < n; i++)
                begin
                    if (it.kind == KIND_SMALL)
                    begin
                        tag_mirror[start + i] = {1'b0, next_dist};
                        next_dist = next_dist + 1'b1;
                    end
                    else
                        tag_mirror[start + i] = TAG_LARGE;
                end
            end
            KIND_LOOKUP:
            begin
                tag = tag_mirror[page_slot(it.address)];
                res.is_large = tag[TAG_W-1];
                res.distance = tag[DIST_W-1:0];
                if (res.is_large)
                    res.header_address = it.address - hdr_bytes;
                else
                begin
                    page = it.address >> PAGE_SHIFT;
                    page = page - res.distance - 1;
                    res.header_address = page << PAGE_SHIFT;
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            base_addr = '0;
            hdr_bytes = LHB_RESET;
            header_q.delete();
            foreach (tag_mirror[j])
                tag_mirror[j] = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen++;
                if (header_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: hdr=%h large=%b dist=%0d oor=%b",
                                 out_item.header_address, out_item.is_large,
                                 out_item.distance, out_item.out_of_range);
                end
                else
                begin
                    want = header_q.pop_front();
                    if (out_item.header_address !== want.header_address ||
                        out_item.is_large !== want.is_large ||
                        out_item.distance !== want.distance ||
                        out_item.out_of_range !== want.out_of_range)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("result %0d mismatch at %0t", seen, $realtime);
                            $display("  expected hdr=%h large=%b dist=%0d oor=%b",
                                     want.header_address, want.is_large,
                                     want.distance, want.out_of_range);
                            $display("  actual   hdr=%h large=%b dist=%0d oor=%b",
                                     out_item.header_address, out_item.is_large,
                                     out_item.distance, out_item.out_of_range);
                        end
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_REGION_BASE: base_addr = cfg_data[ADDR_W-1:0];
                    CFG_LARGE_HDR:   hdr_bytes = cfg_data[LHB_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                header_q.push_back(apply_tag_op(in_item));
        end
        waiting = header_q.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// page tag table regression: directed range registrations and lookups, then
// random phases under several region bases and header sizes, with random
// idling on both sides and a long result hold-off
// ----------------------------------------------------------------------------
module tb;
    import ptt_pkg::*;

    localparam int INDEX_BITS      = 20;
    localparam int PAGE_SHIFT      = 12;
    localparam int TABLE_DEPTH     = 1 << INDEX_BITS;
    localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int IDLE_PCT        = 34;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int SPAN_KEEP       = 24;
    localparam int STALL_LIMIT     = 4 * TABLE_DEPTH + 10000;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0] first;
        int                pages;
    } span_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending_results;
    int results_checked;

    logic [ADDR_W-1:0] region_now = '0;
    span_t             spans [$];
    bit                calm = 1'b0;
    int                hold_asks = 0;
    int                holds_done = 0;
    int                quiet_cycles = 0;
    int                n_small = 0;
    int                n_large = 0;
    int                n_lookup = 0;
    int                n_unused = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    page_tag_table_core #(
        .INDEX_BITS (INDEX_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptt_result_check #(
        .INDEX_BITS (INDEX_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending_results),
        .checked    (results_checked)
    );

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(int unsigned slot);
        logic [ADDR_W-1:0] s;
        s = ADDR_W'(slot);
        return region_now + (s << PAGE_SHIFT);
    endfunction

    task automatic send(in_item_t it);
        @(negedge clk);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        case (it.kind)
            KIND_SMALL:  n_small++;
            KIND_LARGE:  n_large++;
            KIND_LOOKUP: n_lookup++;
            default:     n_unused++;
        endcase
    endtask

    // remembers written ranges so that most lookups land on live tags
    task automatic issue(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
                         logic [ADDR_W-1:0] h, logic [COUNT_W-1:0] c);
        in_item_t          it;
        logic [ADDR_W-1:0] offset;
        int                slot;
        int                pages;
        span_t             sp;
        it.kind                 = k;
        it.address              = a;
        it.block_header_address = h;
        it.page_count           = c;
        send(it);
        if (k == KIND_SMALL || k == KIND_LARGE)
        begin
            offset = a - region_now;
            slot   = offset[PAGE_SHIFT +: INDEX_BITS];
            pages  = (c > TABLE_DEPTH - slot) ? TABLE_DEPTH - slot : c;
            if (pages > 0)
            begin
                sp.first = a;
                sp.pages = pages;
                spans.push_back(sp);
                if (spans.size() > SPAN_KEEP)
                    void'(spans.pop_front());
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(logic [ADDR_W-1:0] base, logic [LHB_W-1:0] hdr_size);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_REGION_BASE;
        cfg_data  <= CFG_W'(base);
        @(negedge clk);
        cfg_index <= CFG_LARGE_HDR;
        cfg_data  <= CFG_W'(hdr_size);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        region_now = base;
    endtask

    task automatic random_item();
        int unsigned         pick;
        int unsigned         sel;
        int unsigned         slot;
        logic [KIND_W-1:0]   k;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W-1:0]   h;
        logic [COUNT_W-1:0]  c;
        span_t               sp;
        pick = $urandom_range(99);
        if (pick < 48)
        begin
            k   = (pick < 32) ? KIND_SMALL : KIND_LARGE;
            sel = $urandom_range(99);
            if (sel < 6)
            begin
                // huge counts only near the table end, so they clip cheaply
                slot = TABLE_DEPTH - 1 - $urandom_range(0, 40);
                c    = COUNT_W'($urandom_range(64, (1 << COUNT_W) - 1));
                a    = slot_addr(slot) + $urandom_range(0, PAGE_BYTES - 1);
            end
            else
            begin
                c   = (sel < 82) ? COUNT_W'($urandom_range(0, 24))
                                 : COUNT_W'($urandom_range(25, 160));
                sel = $urandom_range(99);
                if (sel < 80)
                    a = slot_addr($urandom_range(0, TABLE_DEPTH - 1));
                else if (sel < 92)
                    a = slot_addr(TABLE_DEPTH - 1 - $urandom_range(0, 40));
                else
                    a = rand48();
            end
            if ($urandom_range(99) < 75)
                h = a - (ADDR_W'($urandom_range(0, 300)) << PAGE_SHIFT)
                      - $urandom_range(0, PAGE_BYTES - 1);
            else
                h = rand48();
        end
        else if (pick < 96)
        begin
            k = KIND_LOOKUP;
            h = rand48();
            c = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
            if (spans.size() > 0 && $urandom_range(99) < 80)
            begin
                sp = spans[$urandom_range(0, spans.size() - 1)];
                a  = sp.first + (ADDR_W'($urandom_range(0, sp.pages - 1)) << PAGE_SHIFT);
            end
            else
                a = rand48();
        end
        else
        begin
            k = KIND_UNUSED;
            a = rand48();
            h = rand48();
            c = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
        end
        issue(k, a, h, c);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done++;
                out_ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(negedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("stalled for %0d cycles with %0d results outstanding",
                         quiet_cycles, pending_results);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] a;
        int                p;
        int                i;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset settings
        issue(KIND_LOOKUP, '0, '0, '0);
        issue(KIND_LOOKUP, '1, '0, '0);
        a = slot_addr(256);
        issue(KIND_SMALL, a, a - 3 * PAGE_BYTES + 64, COUNT_W'(200));
        issue(KIND_LOOKUP, a, '0, '0);
        issue(KIND_LOOKUP, a + 125 * PAGE_BYTES + 12'h7ff, '0, '0);
        issue(KIND_LOOKUP, a + 199 * PAGE_BYTES, '0, '0);
        issue(KIND_LOOKUP, a + 200 * PAGE_BYTES, '0, '0);
        a = slot_addr(512) + 12'h123;
        issue(KIND_LARGE, a, rand48(), COUNT_W'(5));
        issue(KIND_LOOKUP, a, '0, '0);
        issue(KIND_LOOKUP, a + 4 * PAGE_BYTES, '0, '0);
        // header below address zero wraps
        issue(KIND_LARGE, slot_addr(0), '0, COUNT_W'(1));
        issue(KIND_LOOKUP, ADDR_W'(16), '0, '0);
        issue(KIND_SMALL, slot_addr(5), rand48(), '0);
        issue(KIND_LOOKUP, slot_addr(5), '0, '0);
        issue(KIND_UNUSED, rand48(), rand48(), '1);
        // exact fit at the table end, then clipped ranges
        a = slot_addr(TABLE_DEPTH - 2);
        issue(KIND_SMALL, a, a - PAGE_BYTES, COUNT_W'(2));
        issue(KIND_SMALL, a, rand48(), COUNT_W'(5));
        issue(KIND_LARGE, slot_addr(TABLE_DEPTH - 16), '0, '1);
        issue(KIND_SMALL, slot_addr(TABLE_DEPTH - 1), rand48(), COUNT_W'(TABLE_DEPTH));
        issue(KIND_LOOKUP, slot_addr(TABLE_DEPTH - 1) + 12'hfff, '0, '0);
        // header equal to address gives the top distance, then wraps
        a = slot_addr(768);
        issue(KIND_SMALL, a, a, COUNT_W'(3));
        issue(KIND_LOOKUP, a + PAGE_BYTES, '0, '0);
        issue(KIND_LOOKUP, rand48(), rand48(), '1);
        settle();

        for (p = 1; p <= PHASES; p++)
        begin
            case (p)
                1:       set_config('0, '0);
                2:       set_config('1, '1);
                3:       set_config(rand48() & ~48'hfff, LHB_W'($urandom_range(1, 4094)));
                4:       set_config(rand48(), LHB_W'($urandom_range(1, 4094)));
                default: set_config(48'h7fff_ffff_f000, LHB_RESET);
            endcase
            spans.delete();
            calm = (p == 2);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    hold_asks++;
                random_item();
            end
            settle();
            calm = 1'b0;
        end

        $display("sent %0d items: %0d small ranges, %0d large ranges, %0d lookups, %0d unused",
                 n_small + n_large + n_lookup + n_unused, n_small, n_large, n_lookup,
                 n_unused);
        $display("%0d results checked over %0d region settings, %0d mismatches",
                 results_checked, PHASES + 1, mismatches);
        if (mismatches == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* page_tag_table_core.f */
+incdir+src
src/ptt_pkg.sv
src/ptt_tag_ram.sv
src/ptt_header_calc.sv
src/page_tag_table_core.sv
tb/ptt_result_check.sv
tb/tb.sv
